### sv/rrmr_pkg.sv
package rrmr_pkg;

    // default ring size and fixed field widths
    localparam int MAX_MEMBERS_DEF = 16;
    localparam int KEY_W           = 16;
    localparam int CNT_W_DEF       = $clog2(MAX_MEMBERS_DEF + 1);

    // request codes
    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_NEXT   = 2'd1,
        OP_SKIP   = 2'd2,
        OP_REMOVE = 2'd3
    } t_opcode;

    // response status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LINK,
        S_RD_CUR,
        S_RD_SEC,
        S_WALK,
        S_RESP
    } t_state;

endpackage

### sv/rrmr_in_if.sv
interface rrmr_in_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  opcode;
    logic [rrmr_pkg::KEY_W-1:0]  member_key;

    modport source (output valid, output opcode, output member_key, input ready);
    modport sink   (input valid, input opcode, input member_key, output ready);
endinterface

### sv/rrmr_out_if.sv
interface rrmr_out_if #(
    parameter int CNT_W = rrmr_pkg::CNT_W_DEF
);
    logic                        valid;
    logic                        ready;
    logic [1:0]                  status;
    logic [rrmr_pkg::KEY_W-1:0]  first_member;
    logic [rrmr_pkg::KEY_W-1:0]  second_member;
    logic [CNT_W-1:0]            member_count;
    logic                        sole_member;
    logic [rrmr_pkg::KEY_W-1:0]  last_standing;

    modport source (output valid, output status, output first_member, output second_member,
                    output member_count, output sole_member, output last_standing,
                    input ready);
    modport sink   (input valid, input status, input first_member, input second_member,
                    input member_count, input sole_member, input last_standing,
                    output ready);
endinterface

### sv/round_robin_member_ring.sv
// Round-robin member ring: keeps up to MAX_MEMBERS member IDs in insertion
// order as a circular linked list, with a turn cursor.
// Request channel i_req carries opcode (add, next, skip, remove) and a
// member_key; response channel o_rsp returns one word per request with
// status, the served/skipped members, member count and the sole survivor.
// Both channels use a valid/ready handshake; a word moves when both are high.
// Keys and links live in one slot memory with a registered read;
// the head, tail, cursor, count and per-slot used bits are in flip-flops.
// Per request: next reads the cursor slot and skip reads it and its
// successor; an add to a full ring, or any other op on an empty ring, goes
// straight to the response; add scans the used bits for the lowest free
// slot, then links the old tail to it when the ring is nonempty; remove
// walks from the head, reading one slot per cycle from the memory, and
// stops at the match or after count slots. One request is worked at a time.
// A new request is taken while the previous response waits in the output
// register; a stalled receiver holds the next response in its final state.
// Synchronous reset empties the ring (used bits, count, pointers cleared);
// the slot memory needs no clearing since only used slots are ever read.
module round_robin_member_ring #(
    parameter int MAX_MEMBERS = rrmr_pkg::MAX_MEMBERS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    rrmr_in_if.sink        i_req,
    rrmr_out_if.source     o_rsp
);

    localparam int IW = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
    localparam int CW = $clog2(MAX_MEMBERS + 1);
    localparam int KW = rrmr_pkg::KEY_W;
    localparam int DW = KW + IW;

    // control state
    rrmr_pkg::t_state    r_state, n_state;
    logic [MAX_MEMBERS-1:0] r_used;
    logic [IW-1:0]       r_tail, r_cursor, r_head;
    logic [CW-1:0]       r_count;
    logic                r_out_valid;

    // working registers
    rrmr_pkg::t_opcode   r_op;
    rrmr_pkg::t_status   r_status;
    logic [KW-1:0]       r_key, r_tail_key, r_prev_key, r_first, r_second;
    logic [IW-1:0]       r_scan, r_new, r_prev, r_cur;
    logic [CW-1:0]       r_step;

    // output word
    logic [1:0]          r_o_status;
    logic [KW-1:0]       r_o_first, r_o_second, r_o_last;
    logic [CW-1:0]       r_o_count;
    logic                r_o_sole;

    // memory ports
    logic                w_rd_en, w_wr_en;
    logic [IW-1:0]       w_rd_addr, w_wr_addr;
    logic [DW-1:0]       w_wr_data, w_rd_data;
    logic [KW-1:0]       w_rd_key;
    logic [IW-1:0]       w_rd_link;

    logic                w_in_acc, w_out_free, w_full, w_empty, w_match, w_last_step;
    logic                w_slot_free;
    rrmr_pkg::t_opcode   w_in_op;

    assign w_in_op     = rrmr_pkg::t_opcode'(i_req.opcode);
    assign i_req.ready = (r_state == rrmr_pkg::S_IDLE);
    assign w_in_acc    = i_req.valid && i_req.ready;
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_full      = (r_count == CW'(MAX_MEMBERS));
    assign w_empty     = (r_count == '0);
    assign w_rd_key    = w_rd_data[DW-1 -: KW];
    assign w_rd_link   = w_rd_data[IW-1:0];
    assign w_match     = (w_rd_key == r_key);
    assign w_last_step = ((r_step + CW'(1)) == r_count);
    assign w_slot_free = !r_used[r_scan];

    rrmr_slot_ram #(
        .DEPTH (MAX_MEMBERS),
        .AW    (IW),
        .DW    (DW)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rrmr_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    if (w_in_op == rrmr_pkg::OP_ADD) begin
                        n_state = w_full ? rrmr_pkg::S_RESP : rrmr_pkg::S_SCAN;
                    end else if (w_empty) begin
                        n_state = rrmr_pkg::S_RESP;
                    end else if (w_in_op == rrmr_pkg::OP_REMOVE) begin
                        n_state = rrmr_pkg::S_WALK;
                    end else begin
                        n_state = rrmr_pkg::S_RD_CUR;
                    end
                end
            end
            rrmr_pkg::S_SCAN: begin
                if (w_slot_free) begin
                    n_state = w_empty ? rrmr_pkg::S_RESP : rrmr_pkg::S_LINK;
                end
            end
            rrmr_pkg::S_LINK:   n_state = rrmr_pkg::S_RESP;
            rrmr_pkg::S_RD_CUR: begin
                n_state = (r_op == rrmr_pkg::OP_SKIP) ? rrmr_pkg::S_RD_SEC
                                                      : rrmr_pkg::S_RESP;
            end
            rrmr_pkg::S_RD_SEC: n_state = rrmr_pkg::S_RESP;
            rrmr_pkg::S_WALK: begin
                if (w_match || w_last_step) begin
                    n_state = rrmr_pkg::S_RESP;
                end
            end
            rrmr_pkg::S_RESP: begin
                if (w_out_free) begin
                    n_state = rrmr_pkg::S_IDLE;
                end
            end
            default: n_state = rrmr_pkg::S_IDLE;
        endcase
    end

    // slot memory reads and writes
    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = r_cursor;
        w_wr_en   = 1'b0;
        w_wr_addr = r_scan;
        w_wr_data = {r_key, r_head};
        case (r_state)
            rrmr_pkg::S_IDLE: begin
                if (w_in_acc && !w_empty && w_in_op != rrmr_pkg::OP_ADD) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = (w_in_op == rrmr_pkg::OP_REMOVE) ? r_head : r_cursor;
                end
            end
            rrmr_pkg::S_SCAN: begin
                // new slot links to itself in an empty ring, else to the head
                if (w_slot_free) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_scan;
                    w_wr_data = {r_key, (w_empty ? r_scan : r_head)};
                end
            end
            rrmr_pkg::S_LINK: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_tail;
                w_wr_data = {r_tail_key, r_new};
            end
            rrmr_pkg::S_RD_CUR: begin
                if (r_op == rrmr_pkg::OP_SKIP) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_rd_link;
                end
            end
            rrmr_pkg::S_WALK: begin
                if (w_match) begin
                    // unlink the matched slot unless it was the only one
                    if (r_count != CW'(1)) begin
                        w_wr_en   = 1'b1;
                        w_wr_addr = r_prev;
                        w_wr_data = {r_prev_key, w_rd_link};
                    end
                end else if (!w_last_step) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_rd_link;
                end
            end
            default: begin
            end
        endcase
    end

    // ring state and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rrmr_pkg::S_IDLE;
            r_used      <= '0;
            r_tail      <= '0;
            r_cursor    <= '0;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // output word valid: set on load, cleared once taken
            if (r_state == rrmr_pkg::S_RESP && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                rrmr_pkg::S_IDLE: begin
                    if (w_in_acc) begin
                        r_op       <= w_in_op;
                        r_key      <= i_req.member_key;
                        r_first    <= '0;
                        r_second   <= '0;
                        r_scan     <= '0;
                        r_prev     <= r_tail;
                        r_prev_key <= r_tail_key;
                        r_cur      <= r_head;
                        r_step     <= '0;
                        if (w_in_op == rrmr_pkg::OP_ADD && w_full) begin
                            r_status <= rrmr_pkg::ST_FULL;
                        end else if (w_in_op != rrmr_pkg::OP_ADD && w_empty) begin
                            r_status <= rrmr_pkg::ST_EMPTY;
                        end else begin
                            r_status <= rrmr_pkg::ST_OK;
                        end
                    end
                end
                rrmr_pkg::S_SCAN: begin
                    // lowest free slot, one used bit per cycle
                    if (w_slot_free) begin
                        r_used[r_scan] <= 1'b1;
                        r_new          <= r_scan;
                        r_count        <= r_count + CW'(1);
                        if (w_empty) begin
                            r_cursor   <= r_scan;
                            r_head     <= r_scan;
                            r_tail     <= r_scan;
                            r_tail_key <= r_key;
                        end
                    end else begin
                        r_scan <= r_scan + IW'(1);
                    end
                end
                rrmr_pkg::S_LINK: begin
                    r_tail     <= r_new;
                    r_tail_key <= r_key;
                end
                rrmr_pkg::S_RD_CUR: begin
                    r_first <= w_rd_key;
                    if (r_op == rrmr_pkg::OP_NEXT) begin
                        r_cursor <= w_rd_link;
                    end
                end
                rrmr_pkg::S_RD_SEC: begin
                    r_second <= w_rd_key;
                    r_cursor <= w_rd_link;
                end
                rrmr_pkg::S_WALK: begin
                    if (w_match) begin
                        r_used[r_cur] <= 1'b0;
                        if (r_count == CW'(1)) begin
                            r_tail   <= '0;
                            r_cursor <= '0;
                            r_head   <= '0;
                            r_count  <= '0;
                        end else begin
                            if (r_cur == r_tail) begin
                                r_tail     <= r_prev;
                                r_tail_key <= r_prev_key;
                            end
                            if (r_cur == r_cursor) begin
                                r_cursor <= w_rd_link;
                            end
                            if (r_cur == r_head) begin
                                r_head <= w_rd_link;
                            end
                            r_count <= r_count - CW'(1);
                        end
                    end else if (w_last_step) begin
                        r_status <= rrmr_pkg::ST_NOTFOUND;
                    end else begin
                        r_prev     <= r_cur;
                        r_prev_key <= w_rd_key;
                        r_cur      <= w_rd_link;
                        r_step     <= r_step + CW'(1);
                    end
                end
                rrmr_pkg::S_RESP: begin
                    // load the output register once it is free
                    if (w_out_free) begin
                        r_o_status  <= r_status;
                        r_o_first   <= r_first;
                        r_o_second  <= r_second;
                        r_o_count   <= r_count;
                        r_o_sole    <= (r_count == CW'(1));
                        r_o_last    <= (r_count == CW'(1)) ? r_tail_key : '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // response channel
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_o_status;
    assign o_rsp.first_member  = r_o_first;
    assign o_rsp.second_member = r_o_second;
    assign o_rsp.member_count  = r_o_count;
    assign o_rsp.sole_member   = r_o_sole;
    assign o_rsp.last_standing = r_o_last;

    // used bits track the member count
    a_used_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_used) == 32'(r_count))
        else $error("used bits disagree with member count");

    // count never exceeds capacity
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_MEMBERS))
        else $error("member count above capacity");

    // cursor, tail and head always point at live slots in a nonempty ring
    a_ptr_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (r_used[r_cursor] && r_used[r_tail] && r_used[r_head]))
        else $error("ring pointer on a free slot");

    // an accepted request starts work
    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state != rrmr_pkg::S_IDLE))
        else $error("request accepted but sequencer idle");

endmodule

### sv/rrmr_slot_ram.sv
module rrmr_slot_ram #(
    parameter int DEPTH = rrmr_pkg::MAX_MEMBERS_DEF,
    parameter int AW    = 4,
    parameter int DW    = 20
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    // one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
